// ===== rtl/frm_pkg.sv =====
// Shared constants and controller/datapath handshake types for the frame rotate/mirror core.
package frm_pkg;

    localparam int DEF_MAX_WIDTH  = 256;
    localparam int DEF_MAX_HEIGHT = 256;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;
    localparam int MODE_W     = 3;
    localparam int CHAN_W     = 8;
    localparam int PIX_W      = 3 * CHAN_W;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TRANSFORM_MODE = 2'd2;

    localparam logic [CFG_DATA_W-1:0] DIM_RESET = 9'd256;

    localparam logic [MODE_W-1:0] MODE_NONE   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_ROT90  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_ROT180 = 3'd2;
    localparam logic [MODE_W-1:0] MODE_ROT270 = 3'd3;
    localparam logic [MODE_W-1:0] MODE_VFLIP  = 3'd4;
    localparam logic [MODE_W-1:0] MODE_HFLIP  = 3'd5;
    localparam logic [MODE_W-1:0] MODE_BOTH   = 3'd6;

    typedef struct packed {
        logic capture;
        logic load;
        logic calc;
        logic mult;
        logic read;
        logic deliver;
    } cmd_t;

    typedef struct packed {
        logic out_free;
    } status_t;

endpackage

// ===== rtl/frm_ctrl.sv =====
// Sequencing state machine for the frame rotate/mirror core.
module frm_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    input  logic             action,
    output logic             s_tready,
    input  frm_pkg::status_t status,
    output frm_pkg::cmd_t    cmd
);
    import frm_pkg::*;

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_LOAD    = 3'd1;
    localparam logic [2:0] ST_CALC    = 3'd2;
    localparam logic [2:0] ST_MULT    = 3'd3;
    localparam logic [2:0] ST_READ    = 3'd4;
    localparam logic [2:0] ST_DELIVER = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       accept;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        cmd         = '0;
        cmd.capture = accept;
        state_next  = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = action ? ST_CALC : ST_LOAD;
                end
            end
            ST_LOAD: begin
                cmd.load   = 1'b1;
                state_next = ST_IDLE;
            end
            ST_CALC: begin
                cmd.calc   = 1'b1;
                state_next = ST_MULT;
            end
            ST_MULT: begin
                cmd.mult   = 1'b1;
                state_next = ST_READ;
            end
            ST_READ: begin
                cmd.read   = 1'b1;
                state_next = ST_DELIVER;
            end
            ST_DELIVER: begin
                if (status.out_free) begin
                    cmd.deliver = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== rtl/frm_datapath.sv =====
// Frame memory, load/emit counters, address arithmetic and output register.
module frm_datapath #(
    parameter int MAX_WIDTH  = frm_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = frm_pkg::DEF_MAX_HEIGHT
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  frm_pkg::cmd_t               cmd,
    output frm_pkg::status_t            status,
    input  logic [frm_pkg::PIX_W-1:0]   in_pixel,
    input  logic [frm_pkg::CFG_DATA_W-1:0] frame_width,
    input  logic [frm_pkg::CFG_DATA_W-1:0] frame_height,
    input  logic [frm_pkg::MODE_W-1:0]  transform_mode,
    input  logic                        m_tready,
    output logic                        m_tvalid,
    output logic [frm_pkg::PIX_W-1:0]   m_tdata,
    output logic                        m_tlast
);
    import frm_pkg::*;

    localparam int DEPTH   = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW      = $clog2(DEPTH);
    localparam int MAX_DIM = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
    localparam int CW      = $clog2(MAX_DIM);
    localparam int DW      = $clog2(MAX_DIM + 1);
    localparam int PW      = CW + DW + 1;

    logic [PIX_W-1:0] mem [DEPTH];

    logic [DW-1:0]    w;
    logic [DW-1:0]    h;
    logic [DW-1:0]    oh;
    logic [DW-1:0]    ow;
    logic             swapped;

    logic [AW:0]      total_reg;
    logic [PIX_W-1:0] pix_reg;
    logic [AW-1:0]    load_idx_reg;
    logic [AW-1:0]    load_addr;
    logic [AW:0]      load_inc;
    logic [AW-1:0]    load_idx_next;

    logic [CW-1:0]    row_reg;
    logic [CW-1:0]    col_reg;
    logic [CW-1:0]    row_next;
    logic [CW-1:0]    col_next;
    logic [DW-1:0]    r;
    logic [DW-1:0]    c;
    logic [DW-1:0]    sr;
    logic [DW-1:0]    sc;
    logic [CW-1:0]    sr_reg;
    logic [CW-1:0]    sc_reg;
    logic             last_reg;
    logic [PW-1:0]    lin;
    logic [AW-1:0]    addr_reg;
    logic [PIX_W-1:0] rd_reg;

    logic             out_valid_reg;
    logic             out_valid_next;
    logic [PIX_W-1:0] out_data_reg;
    logic             out_last_reg;

    always_comb begin
        if (frame_width == '0) begin
            w = DW'(1);
        end else if (32'(frame_width) > MAX_WIDTH) begin
            w = DW'(MAX_WIDTH);
        end else begin
            w = DW'(frame_width);
        end
        if (frame_height == '0) begin
            h = DW'(1);
        end else if (32'(frame_height) > MAX_HEIGHT) begin
            h = DW'(MAX_HEIGHT);
        end else begin
            h = DW'(frame_height);
        end
    end

    assign swapped = (transform_mode == MODE_ROT90) || (transform_mode == MODE_ROT270);
    assign oh      = swapped ? w : h;
    assign ow      = swapped ? h : w;

    // load address: restart when outside the current frame, wrap after the last pixel
    assign load_addr     = ({1'b0, load_idx_reg} >= total_reg) ? '0 : load_idx_reg;
    assign load_inc      = {1'b0, load_addr} + (AW+1)'(1);
    assign load_idx_next = (load_inc >= total_reg) ? '0 : load_inc[AW-1:0];

    // emit position and source coordinate
    always_comb begin
        if (DW'(row_reg) >= oh || DW'(col_reg) >= ow) begin
            r = '0;
            c = '0;
        end else begin
            r = DW'(row_reg);
            c = DW'(col_reg);
        end
        case (transform_mode)
            MODE_ROT90: begin
                sr = h - DW'(1) - c;
                sc = r;
            end
            MODE_ROT180: begin
                sr = h - DW'(1) - r;
                sc = w - DW'(1) - c;
            end
            MODE_ROT270: begin
                sr = c;
                sc = w - DW'(1) - r;
            end
            MODE_VFLIP: begin
                sr = h - DW'(1) - r;
                sc = c;
            end
            MODE_HFLIP: begin
                sr = r;
                sc = w - DW'(1) - c;
            end
            MODE_BOTH: begin
                sr = h - DW'(1) - r;
                sc = w - DW'(1) - c;
            end
            default: begin
                sr = r;
                sc = c;
            end
        endcase
        if (c + DW'(1) >= ow) begin
            col_next = '0;
            row_next = (r + DW'(1) >= oh) ? '0 : CW'(r + DW'(1));
        end else begin
            col_next = CW'(c + DW'(1));
            row_next = CW'(r);
        end
    end

    assign lin = PW'(sr_reg) * PW'(w) + PW'(sc_reg);

    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.deliver) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    assign status.out_free = !out_valid_reg || m_tready;
    assign m_tvalid        = out_valid_reg;
    assign m_tdata         = out_data_reg;
    assign m_tlast         = out_last_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            mem[load_addr] <= pix_reg;
        end
        if (cmd.read) begin
            rd_reg <= mem[addr_reg];
        end
    end

    always_ff @(posedge aclk) begin
        total_reg <= (AW+1)'(w) * (AW+1)'(h);
        if (cmd.capture) begin
            pix_reg <= in_pixel;
        end
        if (cmd.calc) begin
            sr_reg   <= CW'(sr);
            sc_reg   <= CW'(sc);
            last_reg <= (r == oh - DW'(1)) && (c == ow - DW'(1));
        end
        if (cmd.mult) begin
            addr_reg <= AW'(lin);
        end
        if (cmd.deliver) begin
            out_data_reg <= rd_reg;
            out_last_reg <= last_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            load_idx_reg  <= '0;
            row_reg       <= '0;
            col_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
            if (cmd.load) begin
                load_idx_reg <= load_idx_next;
            end
            if (cmd.calc) begin
                row_reg <= row_next;
                col_reg <= col_next;
            end
        end
    end

endmodule

// ===== rtl/frame_rotate_mirror_core.sv =====
// Top level of the frame rotate/mirror core: configuration registers and unit wiring.
//
// A slave beat with s_tuser low loads one pixel into the frame store in row order;
// a beat with s_tuser high emits the next pixel of the transformed frame on the
// master channel, with m_tlast on the final pixel of that frame. Pixels travel as
// red, green, blue from the lowest byte up.
// Configuration goes through the cfg channel (index 0 width, 1 height, 2 mode); the
// user writes it between items, and the core does not enforce this; cfg_ready is always high.
// A load beat captures the pixel, then writes it to the frame store.
// An emit beat passes through position and source coordinate, row-times-width multiply,
// registered frame store read and output register before m_tvalid rises.
// The next beat is accepted only after the controller returns to idle from a load or
// an emit; this is set by the single-port sequencing through multiply and memory read.
// If the receiver stalls, a held result keeps the next emit waiting at its last step
// with s_tready low; no further beats, loads included, are accepted meanwhile.
// Reset clears the load counter, emit position and output valid, and returns width
// and height to 256 and mode to none. Frame store contents are undefined until loaded.
module frame_rotate_mirror_core #(
    parameter int MAX_WIDTH  = frm_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = frm_pkg::DEF_MAX_HEIGHT
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [frm_pkg::PIX_W-1:0]       s_tdata,   // in_red, in_green, in_blue
    input  logic                            s_tuser,   // action
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [frm_pkg::PIX_W-1:0]       m_tdata,   // out_red, out_green, out_blue
    output logic                            m_tlast,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [frm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [frm_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import frm_pkg::*;

    logic [CFG_DATA_W-1:0] frame_width_reg;
    logic [CFG_DATA_W-1:0] frame_height_reg;
    logic [MODE_W-1:0]     transform_mode_reg;
    cmd_t                  cmd;
    status_t               status;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg    <= DIM_RESET;
            frame_height_reg   <= DIM_RESET;
            transform_mode_reg <= MODE_NONE;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_FRAME_WIDTH:    frame_width_reg    <= cfg_data;
                REG_FRAME_HEIGHT:   frame_height_reg   <= cfg_data;
                REG_TRANSFORM_MODE: transform_mode_reg <= cfg_data[MODE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    frm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .action   (s_tuser),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    frm_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .status         (status),
        .in_pixel       (s_tdata),
        .frame_width    (frame_width_reg),
        .frame_height   (frame_height_reg),
        .transform_mode (transform_mode_reg),
        .m_tready       (m_tready),
        .m_tvalid       (m_tvalid),
        .m_tdata        (m_tdata),
        .m_tlast        (m_tlast)
    );

endmodule

// ===== dv/tb.sv =====
// Self-checking testbench for the frame rotate/mirror core: directed table, then random frames.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import frm_pkg::*;

    localparam bit ACT_LOAD = 1'b0;
    localparam bit ACT_EMIT = 1'b1;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam int unsigned STORE_DEPTH = DEF_MAX_WIDTH * DEF_MAX_HEIGHT;
    localparam int RANDOM_ITEMS = 1000;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 12;
    localparam int QUIET_LIMIT  = 20000;
    localparam int REPORT_MAX   = 10;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic              last;
    } pixel_out_t;

    typedef struct {
        int unsigned addr;
        int unsigned row;
        int unsigned col;
        int unsigned out_h;
        int unsigned out_w;
    } emit_pos_t;

    typedef enum {ROW_LOAD, ROW_EMIT, ROW_CFG} row_kind_t;

    typedef struct {
        row_kind_t              kind;
        logic [CFG_IDX_W-1:0]   idx;
        logic [CFG_DATA_W-1:0]  value;
        logic [PIX_W-1:0]       pix;
        bit                     typed;
        pixel_out_t             want;
    } dir_row_t;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic [PIX_W-1:0]       s_tdata   = '0;
    logic                   s_tuser   = 1'b0;
    logic                   m_tready  = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;
    wire                    s_tready;
    wire                    m_tvalid;
    wire  [PIX_W-1:0]       m_tdata;
    wire                    m_tlast;
    wire                    cfg_ready;

    frame_rotate_mirror_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),    // in_red, in_green, in_blue
        .s_tuser   (s_tuser),    // action
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),    // out_red, out_green, out_blue
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    logic [PIX_W-1:0]      frame_store [STORE_DEPTH];
    bit                    loaded      [STORE_DEPTH];
    int unsigned           load_ptr = 0;
    int unsigned           row_ptr  = 0;
    int unsigned           col_ptr  = 0;
    logic [CFG_DATA_W-1:0] width_reg  = DIM_RESET;
    logic [CFG_DATA_W-1:0] height_reg = DIM_RESET;
    logic [MODE_W-1:0]     mode_reg   = MODE_NONE;
    pixel_out_t            pending_pixels [$];

    int mismatches = 0;
    int send_idle  = 0;
    int stall_pct  = 0;
    int hold_reqs  = 0;
    int hold_seen  = 0;
    int hold_left  = 0;
    int quiet      = 0;

    initial begin
        forever #2 aclk = ~aclk;
    end

    function automatic int unsigned eff_dim(logic [CFG_DATA_W-1:0] v, int unsigned maxv);
        if (v == 0) return 1;
        if (v > maxv) return maxv;
        return v;
    endfunction

    function automatic logic [PIX_W-1:0] pack_pix(logic [7:0] r, logic [7:0] g, logic [7:0] b);
        return {b, g, r};
    endfunction

    function automatic emit_pos_t locate_emit();
        emit_pos_t   p;
        int unsigned w;
        int unsigned h;
        int unsigned sr;
        int unsigned sc;
        bit          swapped;
        w = eff_dim(width_reg, DEF_MAX_WIDTH);
        h = eff_dim(height_reg, DEF_MAX_HEIGHT);
        swapped = (mode_reg == MODE_ROT90) || (mode_reg == MODE_ROT270);
        p.out_h = swapped ? w : h;
        p.out_w = swapped ? h : w;
        p.row = row_ptr;
        p.col = col_ptr;
        if (p.row >= p.out_h || p.col >= p.out_w) begin
            p.row = 0;
            p.col = 0;
        end
        case (mode_reg)
            MODE_ROT90: begin
                sr = h - 1 - p.col;
                sc = p.row;
            end
            MODE_ROT180, MODE_BOTH: begin
                sr = h - 1 - p.row;
                sc = w - 1 - p.col;
            end
            MODE_ROT270: begin
                sr = p.col;
                sc = w - 1 - p.row;
            end
            MODE_VFLIP: begin
                sr = h - 1 - p.row;
                sc = p.col;
            end
            MODE_HFLIP: begin
                sr = p.row;
                sc = w - 1 - p.col;
            end
            default: begin
                sr = p.row;
                sc = p.col;
            end
        endcase
        p.addr = (sr * w + sc) % STORE_DEPTH;
        return p;
    endfunction

    function automatic dir_row_t row_load(logic [7:0] r, logic [7:0] g, logic [7:0] b);
        dir_row_t row;
        row = '{kind: ROW_LOAD, idx: '0, value: '0, pix: pack_pix(r, g, b), typed: 1'b0,
                want: '0};
        return row;
    endfunction

    function automatic dir_row_t row_emit(bit typed, logic [7:0] r, logic [7:0] g,
                                          logic [7:0] b, logic last);
        dir_row_t row;
        row = '{kind: ROW_EMIT, idx: '0, value: '0, pix: pack_pix(8'h3c, 8'hc3, 8'h99),
                typed: typed, want: '{red: r, green: g, blue: b, last: last}};
        return row;
    endfunction

    function automatic dir_row_t row_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        dir_row_t row;
        row = '{kind: ROW_CFG, idx: idx, value: value, pix: '0, typed: 1'b0, want: '0};
        return row;
    endfunction

    task automatic issue(input bit action, input logic [PIX_W-1:0] pix, input bit typed,
                         input pixel_out_t want);
        emit_pos_t   p;
        bit          act;
        int unsigned total;
        pixel_out_t  res;
        act = action;
        if (act == ACT_EMIT) begin
            p = locate_emit();
            if (!loaded[p.addr]) act = ACT_LOAD;
        end
        while ($urandom_range(99) < send_idle) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= pix;
        do @(posedge aclk); while (!s_tready);
        if (act == ACT_LOAD) begin
            total = eff_dim(width_reg, DEF_MAX_WIDTH) * eff_dim(height_reg, DEF_MAX_HEIGHT);
            if (load_ptr >= total) load_ptr = 0;
            frame_store[load_ptr] = pix;
            loaded[load_ptr] = 1'b1;
            load_ptr++;
            if (load_ptr >= total) load_ptr = 0;
        end else begin
            p = locate_emit();
            res.red   = frame_store[p.addr][7:0];
            res.green = frame_store[p.addr][15:8];
            res.blue  = frame_store[p.addr][23:16];
            res.last  = (p.row == p.out_h - 1) && (p.col == p.out_w - 1);
            pending_pixels = {pending_pixels, (typed ? want : res)};
            row_ptr = p.row;
            col_ptr = p.col + 1;
            if (col_ptr >= p.out_w) begin
                col_ptr = 0;
                row_ptr++;
                if (row_ptr >= p.out_h) row_ptr = 0;
            end
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            REG_FRAME_WIDTH:    width_reg  = value;
            REG_FRAME_HEIGHT:   height_reg = value;
            REG_TRANSFORM_MODE: mode_reg   = value[MODE_W-1:0];
            default: ;
        endcase
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // receiver: random stalls, plus one long hold-off on request
    always @(posedge aclk) begin
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_tready <= 1'b0;
        end else if (hold_reqs != hold_seen) begin
            hold_seen = hold_reqs;
            hold_left = HOLD_CYCLES;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge aclk) begin : check_pixels
        pixel_out_t want;
        pixel_out_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got.red   = m_tdata[7:0];
            got.green = m_tdata[15:8];
            got.blue  = m_tdata[23:16];
            got.last  = m_tlast;
            if (pending_pixels.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("unexpected output beat: rgb %h %h %h last %b",
                             got.red, got.green, got.blue, got.last);
            end else begin
                want = pending_pixels.pop_front();
                if (got.red !== want.red || got.green !== want.green ||
                    got.blue !== want.blue || got.last !== want.last) begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display({"pixel mismatch: expected rgb %h %h %h last %b, ",
                                  "got %h %h %h last %b"},
                                 want.red, want.green, want.blue, want.last,
                                 got.red, got.green, got.blue, got.last);
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet = 0;
        else
            quiet = quiet + 1;
        if (quiet >= QUIET_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin : stimulus
        dir_row_t              rows [$];
        bit                    cfg_open;
        bit                    hold_done;
        int                    random_count;
        int                    phase;
        int unsigned           total;
        int unsigned           n;
        logic [CFG_DATA_W-1:0] wv;
        logic [CFG_DATA_W-1:0] hv;
        logic [CFG_DATA_W-1:0] big;
        logic [CFG_DATA_W-1:0] tiny;
        logic [MODE_W-1:0]     mv;
        logic [5:0]            junk;
        pixel_out_t            none;

        none = '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        rows = {rows, row_load(8'h00, 8'h00, 8'h00)};
        rows = {rows, row_load(8'hff, 8'hff, 8'hff)};
        rows = {rows, row_load(8'h12, 8'h34, 8'h56)};
        rows = {rows, row_emit(1'b1, 8'h00, 8'h00, 8'h00, 1'b0)};
        rows = {rows, row_emit(1'b1, 8'hff, 8'hff, 8'hff, 1'b0)};
        rows = {rows, row_emit(1'b1, 8'h12, 8'h34, 8'h56, 1'b0)};
        // zero width acts as one: single-pixel frame, counters restart
        rows = {rows, row_cfg(REG_FRAME_WIDTH, 9'd0)};
        rows = {rows, row_cfg(REG_FRAME_HEIGHT, 9'd1)};
        rows = {rows, row_load(8'ha5, 8'h5a, 8'hc3)};
        rows = {rows, row_emit(1'b1, 8'ha5, 8'h5a, 8'hc3, 1'b1)};
        rows = {rows, row_emit(1'b1, 8'ha5, 8'h5a, 8'hc3, 1'b1)};
        rows = {rows, row_cfg(REG_FRAME_WIDTH, 9'd3)};
        rows = {rows, row_cfg(REG_FRAME_HEIGHT, 9'd2)};
        rows = {rows, row_cfg(REG_TRANSFORM_MODE, {6'd0, MODE_ROT90})};
        rows = {rows, row_cfg(REG_UNUSED, 9'h1ff)};
        for (int i = 0; i < 6; i++)
            rows = {rows, row_load(8'(16 * i + 1), 8'(16 * i + 2), 8'(16 * i + 3))};
        for (int i = 0; i < 6; i++)
            rows = {rows, row_emit(1'b0, 8'h00, 8'h00, 8'h00, 1'b0)};
        // unused mode code with upper data bits set acts as identity
        rows = {rows, row_cfg(REG_TRANSFORM_MODE, 9'h1ff)};
        rows = {rows, row_emit(1'b0, 8'h00, 8'h00, 8'h00, 1'b0)};
        rows = {rows, row_emit(1'b0, 8'h00, 8'h00, 8'h00, 1'b0)};

        cfg_open = 1'b0;
        foreach (rows[i]) begin
            if (rows[i].kind == ROW_CFG) begin
                if (!cfg_open) begin
                    settle();
                    cfg_open = 1'b1;
                end
                write_reg(rows[i].idx, rows[i].value);
            end else begin
                if (cfg_open) begin
                    cfg_valid <= 1'b0;
                    cfg_open = 1'b0;
                end
                issue(rows[i].kind == ROW_EMIT ? ACT_EMIT : ACT_LOAD, rows[i].pix,
                      rows[i].typed, rows[i].want);
            end
        end

        random_count = 0;
        phase = 0;
        hold_done = 1'b0;
        while (random_count < RANDOM_ITEMS || !hold_done) begin
            settle();
            case (phase % 4)
                0: begin
                    send_idle = 0;
                    stall_pct <= 0;
                end
                1: begin
                    send_idle = 52;
                    stall_pct <= 0;
                end
                2: begin
                    send_idle = 0;
                    stall_pct <= 52;
                end
                default: begin
                    send_idle = 16;
                    stall_pct <= 16;
                end
            endcase

            if ($urandom_range(99) < 12) begin
                big  = 9'($urandom_range(256, 511));
                tiny = 9'($urandom_range(0, 1));
                if ($urandom_range(1)) begin
                    wv = big;
                    hv = tiny;
                end else begin
                    wv = tiny;
                    hv = big;
                end
            end else begin
                wv = 9'($urandom_range(0, 8));
                hv = 9'($urandom_range(0, 8));
            end
            mv   = 3'($urandom_range(0, 7));
            junk = 6'($urandom_range(0, 63));
            if (phase < 2 || $urandom_range(3) != 0) write_reg(REG_FRAME_WIDTH, wv);
            if (phase < 2 || $urandom_range(3) != 0) write_reg(REG_FRAME_HEIGHT, hv);
            if (phase < 2 || $urandom_range(3) != 0) write_reg(REG_TRANSFORM_MODE, {junk, mv});
            if ($urandom_range(9) == 0) write_reg(REG_UNUSED, 9'($urandom_range(0, 511)));
            cfg_valid <= 1'b0;

            total = eff_dim(width_reg, DEF_MAX_WIDTH) * eff_dim(height_reg, DEF_MAX_HEIGHT);
            if ($urandom_range(99) < 75) begin
                for (int unsigned i = 0; i < total; i++)
                    issue(ACT_LOAD, PIX_W'($urandom()), 1'b0, none);
                // hold the receiver off while emits keep coming
                if (!hold_done && phase >= 2 && total >= 8) begin
                    hold_reqs <= hold_reqs + 1;
                    hold_done = 1'b1;
                end
                n = ($urandom_range(3) == 0) ? $urandom_range(1, total) : total;
                for (int unsigned i = 0; i < n; i++)
                    issue(ACT_EMIT, PIX_W'($urandom()), 1'b0, none);
                random_count += total + n;
            end else begin
                n = $urandom_range(1, 40);
                for (int unsigned i = 0; i < n; i++)
                    issue(1'($urandom_range(1)), PIX_W'($urandom()), 1'b0, none);
                random_count += n;
            end
            phase++;
        end

        settle();
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
